/* sv/mte_pkg.sv */
// ----------------------------------------------------------------------------
// mte_pkg
// Types and constants shared by the MIDI track event encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

  typedef enum logic [2:0] {
    CMD_DELTA   = 3'd0,
    CMD_TEMPO   = 3'd1,
    CMD_PROGRAM = 3'd2,
    CMD_CONTROL = 3'd3,
    CMD_NOTE_ON = 3'd4,
    CMD_NOTE_OFF = 3'd5,
    CMD_TIMED   = 3'd6,
    CMD_END     = 3'd7
  } cmd_t;

  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_CONTROL  = 8'hB0;
  localparam logic [7:0] ST_PROGRAM  = 8'hC0;
  localparam logic [7:0] META_BYTE   = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] TEMPO_LEN   = 8'h03;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] VLQ_CONT    = 8'h80;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  channel;
    logic [7:0]  key;
    logic [7:0]  level;
    logic [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

endpackage

`default_nettype wire

/* sv/midi_track_event_encoder.sv */
// ----------------------------------------------------------------------------
// midi_track_event_encoder
// Serializes one track event command into standard MIDI file bytes, one
// result transfer per byte, with the final byte of each command marked last.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    mte_pkg::in_item_t
//   out_     output     out_valid/out_stall  mte_pkg::out_item_t
//
// A command emits 1 to 11 bytes, which the single byte-index counter walks
// from the held command into the result register.
// The next command is taken in the cycle its predecessor's last byte moves
// to the result register, so commands stream back to back.
// Reset clears the busy flag, the byte index and the result valid flag.
// A stall on the output holds the result register and the byte index.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_event_encoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mte_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mte_pkg::out_item_t      out_data
);

  mte_pkg::in_item_t  cur_r, cur_nxt;
  logic               busy_r, busy_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  mte_pkg::out_item_t out_r, out_nxt;

  logic [27:0] vlq_val;
  logic [2:0]  vlq_n;
  logic [3:0]  len_c;
  logic [3:0]  tail_j;
  logic [3:0]  tail_k;
  logic [7:0]  byte_c;
  logic        err_c;
  logic        last_c;
  logic        adv;
  logic        take;
  logic [7:0]  ch_b;
  logic [7:0]  key_b;
  logic [7:0]  lvl_b;

  function automatic logic [7:0] vlq_byte(input logic [27:0] v, input logic [2:0] n,
                                          input logic [3:0] i);
    logic [1:0] g;
    logic [6:0] grp;
    logic [7:0] res;
    g = n[1:0] - 2'd1 - i[1:0];
    case (g)
      2'd0:    grp = v[6:0];
      2'd1:    grp = v[13:7];
      2'd2:    grp = v[20:14];
      default: grp = v[27:21];
    endcase
    res = {1'b0, grp};
    if ({1'b0, i} < {2'b00, n} - 5'd1) begin
      res = res | mte_pkg::VLQ_CONT;
    end
    return res;
  endfunction

  always_comb begin
    ch_b    = {4'h0, cur_r.channel[3:0]};
    key_b   = {1'b0, cur_r.key[6:0]};
    lvl_b   = {1'b0, cur_r.level[6:0]};
    vlq_val = cur_r.amount[27:0];
    if (vlq_val[27:21] != 7'd0) begin
      vlq_n = 3'd4;
    end else if (vlq_val[20:14] != 7'd0) begin
      vlq_n = 3'd3;
    end else if (vlq_val[13:7] != 7'd0) begin
      vlq_n = 3'd2;
    end else begin
      vlq_n = 3'd1;
    end
    err_c  = ((cur_r.cmd == mte_pkg::CMD_DELTA) || (cur_r.cmd == mte_pkg::CMD_TIMED)) &&
             (cur_r.amount[31:28] != 4'h0);
    tail_j = idx_r - 4'd4;
    tail_k = tail_j - {1'b0, vlq_n};
    len_c  = 4'd1;
    byte_c = 8'h00;
    if (err_c) begin
      len_c  = 4'd1;
      byte_c = 8'h00;
    end else begin
      case (cur_r.cmd)
        mte_pkg::CMD_DELTA: begin
          len_c  = {1'b0, vlq_n};
          byte_c = vlq_byte(vlq_val, vlq_n, idx_r);
        end
        mte_pkg::CMD_TEMPO: begin
          len_c = 4'd7;
          case (idx_r)
            4'd1:    byte_c = mte_pkg::META_BYTE;
            4'd2:    byte_c = mte_pkg::META_TEMPO;
            4'd3:    byte_c = mte_pkg::TEMPO_LEN;
            4'd4:    byte_c = cur_r.amount[23:16];
            4'd5:    byte_c = cur_r.amount[15:8];
            4'd6:    byte_c = cur_r.amount[7:0];
            default: byte_c = 8'h00;
          endcase
        end
        mte_pkg::CMD_PROGRAM: begin
          len_c = 4'd3;
          case (idx_r)
            4'd1:    byte_c = mte_pkg::ST_PROGRAM | ch_b;
            4'd2:    byte_c = key_b;
            default: byte_c = 8'h00;
          endcase
        end
        mte_pkg::CMD_CONTROL: begin
          len_c = 4'd4;
          case (idx_r)
            4'd1:    byte_c = mte_pkg::ST_CONTROL | ch_b;
            4'd2:    byte_c = key_b;
            4'd3:    byte_c = lvl_b;
            default: byte_c = 8'h00;
          endcase
        end
        mte_pkg::CMD_NOTE_ON, mte_pkg::CMD_NOTE_OFF: begin
          len_c = 4'd3;
          case (idx_r)
            4'd0: begin
              byte_c = ((cur_r.cmd == mte_pkg::CMD_NOTE_ON) ? mte_pkg::ST_NOTE_ON :
                        mte_pkg::ST_NOTE_OFF) | ch_b;
            end
            4'd1:    byte_c = key_b;
            default: byte_c = lvl_b;
          endcase
        end
        mte_pkg::CMD_TIMED: begin
          len_c = 4'd7 + {1'b0, vlq_n};
          case (idx_r)
            4'd0: byte_c = 8'h00;
            4'd1: byte_c = mte_pkg::ST_NOTE_ON | ch_b;
            4'd2: byte_c = key_b;
            4'd3: byte_c = lvl_b;
            default: begin
              if (tail_j < {1'b0, vlq_n}) begin
                byte_c = vlq_byte(vlq_val, vlq_n, tail_j);
              end else if (tail_k == 4'd0) begin
                byte_c = mte_pkg::ST_NOTE_OFF | ch_b;
              end else if (tail_k == 4'd1) begin
                byte_c = key_b;
              end else begin
                byte_c = 8'h00;
              end
            end
          endcase
        end
        default: begin
          len_c = 4'd4;
          case (idx_r)
            4'd1:    byte_c = mte_pkg::META_BYTE;
            4'd2:    byte_c = mte_pkg::META_EOT;
            default: byte_c = 8'h00;
          endcase
        end
      endcase
    end
    last_c = (idx_r == len_c - 4'd1);
  end

  assign adv      = busy_r && (!out_valid_r || !out_stall);
  assign in_stall = busy_r && !(adv && last_c);
  assign take     = in_valid && !in_stall;

  always_comb begin
    cur_nxt       = cur_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (take) begin
      cur_nxt  = in_data;
      busy_nxt = 1'b1;
      idx_nxt  = 4'd0;
    end else if (adv && last_c) begin
      busy_nxt = 1'b0;
      idx_nxt  = 4'd0;
    end else if (adv) begin
      idx_nxt = idx_r + 4'd1;
    end
    if (adv) begin
      out_valid_nxt    = 1'b1;
      out_nxt.out_byte = byte_c;
      out_nxt.last     = last_c;
      out_nxt.error    = err_c;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MIDI track event encoder. Track events are
// offered with random gaps and the result side stalls at random. Each
// accepted event is encoded by a bench-side model into the expected byte
// stream, and every result transfer is checked against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 150;
  localparam logic [31:0] VLQ_LIMIT   = 32'h0FFF_FFFF;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  mte_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mte_pkg::out_item_t out_data;

  mte_pkg::in_item_t  pending_events[$];
  int                 pending_gaps[$];
  bit                 pending_drain[$];
  mte_pkg::out_item_t expected_bytes[$];
  logic [7:0]         enc_bytes[$];

  bit in_taken;
  bit out_taken;
  bit hold_done;
  int stall_left;
  int hold_left;
  int cycle_cnt;
  int mismatches;
  int events_sent;
  int bytes_seen;
  int error_results;

  midi_track_event_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** midi_track_event_encoder: FAILED **");
      $finish;
    end
  end

  function automatic void add_vlq(logic [31:0] value);
    logic [6:0]  grp [4];
    logic [31:0] rest;
    int          n;
    int          i;
    rest = value & VLQ_LIMIT;
    n = 0;
    do begin
      grp[n] = rest[6:0];
      rest = rest >> 7;
      n++;
    end while (rest != 0 && n < 4);
    for (i = n - 1; i > 0; i--) begin
      enc_bytes.push_back(mte_pkg::VLQ_CONT | {1'b0, grp[i]});
    end
    enc_bytes.push_back({1'b0, grp[0]});
  endfunction

  function automatic void add_channel_msg(logic [7:0] status, logic [3:0] ch,
                                          logic [7:0] nk, logic [7:0] lv);
    enc_bytes.push_back(status | {4'h0, ch});
    enc_bytes.push_back(nk);
    enc_bytes.push_back(lv);
  endfunction

  function automatic void encode_event(mte_pkg::in_item_t ev);
    logic [3:0]         ch;
    logic [7:0]         nk;
    logic [7:0]         lv;
    mte_pkg::out_item_t res;
    int                 i;
    ch = ev.channel[3:0];
    nk = {1'b0, ev.key[6:0]};
    lv = {1'b0, ev.level[6:0]};
    enc_bytes.delete();
    if ((ev.cmd == mte_pkg::CMD_DELTA || ev.cmd == mte_pkg::CMD_TIMED) &&
        ev.amount > VLQ_LIMIT) begin
      res.out_byte = 8'h00;
      res.last     = 1'b1;
      res.error    = 1'b1;
      expected_bytes.push_back(res);
      return;
    end
    case (ev.cmd)
      mte_pkg::CMD_DELTA: begin
        add_vlq(ev.amount);
      end
      mte_pkg::CMD_TEMPO: begin
        enc_bytes.push_back(8'h00);
        enc_bytes.push_back(mte_pkg::META_BYTE);
        enc_bytes.push_back(mte_pkg::META_TEMPO);
        enc_bytes.push_back(mte_pkg::TEMPO_LEN);
        enc_bytes.push_back(ev.amount[23:16]);
        enc_bytes.push_back(ev.amount[15:8]);
        enc_bytes.push_back(ev.amount[7:0]);
      end
      mte_pkg::CMD_PROGRAM: begin
        enc_bytes.push_back(8'h00);
        enc_bytes.push_back(mte_pkg::ST_PROGRAM | {4'h0, ch});
        enc_bytes.push_back(nk);
      end
      mte_pkg::CMD_CONTROL: begin
        enc_bytes.push_back(8'h00);
        add_channel_msg(mte_pkg::ST_CONTROL, ch, nk, lv);
      end
      mte_pkg::CMD_NOTE_ON: begin
        add_channel_msg(mte_pkg::ST_NOTE_ON, ch, nk, lv);
      end
      mte_pkg::CMD_NOTE_OFF: begin
        add_channel_msg(mte_pkg::ST_NOTE_OFF, ch, nk, lv);
      end
      mte_pkg::CMD_TIMED: begin
        enc_bytes.push_back(8'h00);
        add_channel_msg(mte_pkg::ST_NOTE_ON, ch, nk, lv);
        add_vlq(ev.amount);
        add_channel_msg(mte_pkg::ST_NOTE_OFF, ch, nk, 8'h00);
      end
      default: begin
        enc_bytes.push_back(8'h00);
        enc_bytes.push_back(mte_pkg::META_BYTE);
        enc_bytes.push_back(mte_pkg::META_EOT);
        enc_bytes.push_back(8'h00);
      end
    endcase
    for (i = 0; i < enc_bytes.size(); i++) begin
      res.out_byte = enc_bytes[i];
      res.last     = (i == enc_bytes.size() - 1);
      res.error    = 1'b0;
      expected_bytes.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    mte_pkg::out_item_t want;
    out_taken = rst_n && out_valid && !out_stall;
    in_taken  = rst_n && in_valid && !in_stall;
    if (out_taken) begin
      bytes_seen++;
      if (out_data.error) begin
        error_results++;
      end
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %h last %b error %b",
               out_data.out_byte, out_data.last, out_data.error);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data.last);
          mismatches++;
        end
        if (out_data.error !== want.error) begin
          $error("error: expected %b, got %b", want.error, out_data.error);
          mismatches++;
        end
      end
    end
    if (in_taken) begin
      encode_event(in_data);
      events_sent++;
    end
  end

  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = in_valid;
    if (in_valid && in_taken) begin
      nxt_valid = 1'b0;
    end
    if (rst_n && !nxt_valid && pending_events.size() != 0) begin
      if (pending_gaps[0] > 0) begin
        pending_gaps[0] = pending_gaps[0] - 1;
      end else if (!pending_drain[0] || expected_bytes.size() == 0) begin
        in_data <= pending_events[0];
        void'(pending_events.pop_front());
        void'(pending_gaps.pop_front());
        void'(pending_drain.pop_front());
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
  end

  always @(negedge clk) begin
    bit quiet;
    quiet = (bytes_seen >= 200 && bytes_seen < 320);
    if (out_taken) begin
      stall_left = (quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 14);
    end
    if (!hold_done && events_sent >= 64) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_event(input mte_pkg::cmd_t c, input logic [7:0] ch,
                             input logic [7:0] nk, input logic [7:0] lv,
                             input logic [31:0] amt, input int gap, input bit drain);
    mte_pkg::in_item_t ev;
    ev.cmd     = c;
    ev.channel = ch;
    ev.key     = nk;
    ev.level   = lv;
    ev.amount  = amt;
    pending_events.push_back(ev);
    pending_gaps.push_back(gap);
    pending_drain.push_back(drain);
  endtask

  initial begin
    mte_pkg::cmd_t c;
    logic [31:0]   amt;
    int            nb;
    int            gap;
    int            i;

    queue_event(mte_pkg::CMD_DELTA,    8'h00, 8'h00, 8'h00, 32'h0000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'hFF, 8'hFF, 8'hFF, 32'h0000_007F, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'h00, 8'h00, 8'h00, 32'h0000_0080, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'h00, 8'h00, 8'h00, 32'h0000_3FFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'h00, 8'h00, 8'h00, 32'h0000_4000, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'h00, 8'h00, 8'h00, 32'h001F_FFFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'h00, 8'h00, 8'h00, 32'h0020_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'h00, 8'h00, 8'h00, 32'h0FFF_FFFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'h00, 8'h00, 8'h00, 32'h1000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_DELTA,    8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_TEMPO,    8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_TEMPO,    8'h00, 8'h00, 8'h00, 32'h0007_A120, 0, 1'b0);
    queue_event(mte_pkg::CMD_PROGRAM,  8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_PROGRAM,  8'h00, 8'h80, 8'h00, 32'h0000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_CONTROL,  8'h0F, 8'h7F, 8'hFF, 32'h0000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_CONTROL,  8'hF0, 8'h00, 8'h80, 32'h0000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_NOTE_ON,  8'hA5, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_NOTE_ON,  8'h00, 8'h00, 8'h00, 32'h0000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_NOTE_OFF, 8'hFF, 8'h80, 8'h7F, 32'h0000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_TIMED,    8'hFF, 8'hFF, 8'hFF, 32'h0FFF_FFFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_TIMED,    8'h03, 8'h3C, 8'h40, 32'h1000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_TIMED,    8'h03, 8'h3C, 8'h40, 32'h0000_0000, 0, 1'b0);
    queue_event(mte_pkg::CMD_TIMED,    8'h5A, 8'hC3, 8'h96, 32'hFFFF_FFFF, 0, 1'b0);
    queue_event(mte_pkg::CMD_END,      8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 1'b0);

    for (i = 0; i < 86; i++) begin
      c = mte_pkg::cmd_t'($urandom_range(0, 7));
      if (c == mte_pkg::CMD_DELTA || c == mte_pkg::CMD_TIMED) begin
        if ($urandom_range(0, 7) == 0) begin
          amt = $urandom();
        end else begin
          nb = $urandom_range(1, 4);
          amt = $urandom() & ((32'h1 << (7 * nb)) - 1);
        end
      end else begin
        amt = $urandom();
      end
      if (i >= 40 && i < 60) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
      end
      queue_event(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), amt, gap, (i == 0 || i == 75));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_events.size() != 0 || in_valid) @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Encoded %0d track events into %0d result transfers, %0d of them oversized",
             events_sent, bytes_seen, error_results);
    $display("delta errors, with a %0d-cycle output hold and full drains mid-run.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("** midi_track_event_encoder: PASSED **");
    end else begin
      $display("** midi_track_event_encoder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/mte_pkg.sv
sv/midi_track_event_encoder.sv
verif/tb.sv
